FILE: src/csrsp_pkg.sv
// shared types and constants for the csr sparse matrix-vector scaled-add core
// no dependencies
`default_nettype none

package csrsp_pkg;

    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_NONZERO = 2'd1;
    localparam logic [1:0] MODE_CLOSE   = 2'd2;

    localparam logic       REG_DAMPING  = 1'b0;

    localparam logic [30:0] ALPHA_RESET = 31'd912680550;

    localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic [1:0]         mode;
        logic [9:0]         index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         row_index;
        logic signed [31:0] rank_value;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic               close;
        logic               xok;
        logic [9:0]         row;
        logic signed [31:0] value;
    } t_mac_item;

    typedef struct packed {
        logic [9:0]         row;
        logic signed [47:0] sum;
        logic signed [31:0] z;
    } t_close_xact;

endpackage

`default_nettype wire

FILE: src/csrsp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module csrsp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/csrsp_mac.sv
// multiply stage and row accumulator: value times x, floor shift, saturating sum
// depends on csrsp_pkg
`default_nettype none

module csrsp_mac (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    input  wire csrsp_pkg::t_mac_item     i_item,
    input  wire logic signed [31:0]       i_x,
    output logic                          o_ready,
    output logic                          o_valid,
    output csrsp_pkg::t_close_xact        o_xact,
    input  wire logic                     i_ready
);
    import csrsp_pkg::*;

    logic               r_s1_valid;
    t_mac_item          r_s1_item;
    logic               r_s2_valid;
    logic               r_s2_close;
    logic [9:0]         r_s2_row;
    logic signed [63:0] r_s2_data;
    logic signed [47:0] r_row_sum;

    logic               w_mv1;
    logic               w_mv2;
    logic               w_ld2;
    logic signed [63:0] w_prod;
    logic signed [63:0] n_s2_data;
    logic signed [33:0] w_term;
    logic signed [48:0] w_sum;
    logic signed [47:0] n_row_sum;

    assign w_mv2   = r_s2_valid && (!r_s2_close || i_ready);
    assign w_ld2   = !r_s2_valid || w_mv2;
    assign w_mv1   = r_s1_valid && w_ld2;
    assign o_ready = !r_s1_valid || w_ld2;

    always_comb begin
        w_prod = r_s1_item.value * i_x;
        if (r_s1_item.close) begin
            n_s2_data = {{32{r_s1_item.value[31]}}, r_s1_item.value};
        end else if (r_s1_item.xok) begin
            n_s2_data = w_prod;
        end else begin
            n_s2_data = '0;
        end
    end

    always_comb begin
        w_term = r_s2_data[63:30];
        w_sum  = {r_row_sum[47], r_row_sum} + {{15{w_term[33]}}, w_term};
        if (w_sum[48] != w_sum[47]) begin
            n_row_sum = w_sum[48] ? SUM_MIN : SUM_MAX;
        end else begin
            n_row_sum = w_sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_row_sum  <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_ld2) begin
                r_s2_valid <= w_mv1;
            end
            if (w_mv2) begin
                r_row_sum <= r_s2_close ? '0 : n_row_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_item <= i_item;
        end
        if (w_mv1) begin
            r_s2_close <= r_s1_item.close;
            r_s2_row   <= r_s1_item.row;
            r_s2_data  <= n_s2_data;
        end
    end

    assign o_valid    = r_s2_valid && r_s2_close;
    assign o_xact.row = r_s2_row;
    assign o_xact.sum = r_row_sum;
    assign o_xact.z   = r_s2_data[31:0];

endmodule

`default_nettype wire

FILE: src/csrsp_scale.sv
// damping scale of the closed row sum, z add and signed q2.30 saturation
// depends on csrsp_pkg
`default_nettype none

module csrsp_scale (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [30:0]            i_alpha,
    input  wire logic                   i_valid,
    input  wire csrsp_pkg::t_close_xact i_xact,
    output logic                        o_ready,
    output logic                        o_valid,
    output csrsp_pkg::t_out_item        o_item,
    input  wire logic                   i_stall
);
    import csrsp_pkg::*;

    logic               r_s3_valid;
    t_close_xact        r_s3;
    logic               r_s4_valid;
    logic signed [49:0] r_s4_phi;
    logic [60:0]        r_s4_plo;
    logic signed [31:0] r_s4_z;
    logic [9:0]         r_s4_row;
    logic               r_s5_valid;
    t_out_item          r_s5;

    logic               w_ld3;
    logic               w_ld4;
    logic               w_ld5;
    logic signed [49:0] w_phi;
    logic [60:0]        w_plo;
    logic signed [50:0] w_res;
    t_out_item          n_s5;

    assign w_ld5   = !r_s5_valid || !i_stall;
    assign w_ld4   = !r_s4_valid || w_ld5;
    assign w_ld3   = !r_s3_valid || w_ld4;
    assign o_ready = w_ld3;

    always_comb begin
        w_phi = $signed({1'b0, i_alpha}) * $signed(r_s3.sum[47:30]);
        w_plo = i_alpha * r_s3.sum[29:0];
    end

    always_comb begin
        w_res = {r_s4_phi[49], r_s4_phi} + 51'(r_s4_plo[60:30])
              + {{19{r_s4_z[31]}}, r_s4_z};
        n_s5.row_index = r_s4_row;
        if (w_res[50:31] != {20{w_res[50]}}) begin
            n_s5.saturated  = 1'b1;
            n_s5.rank_value = w_res[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            n_s5.saturated  = 1'b0;
            n_s5.rank_value = w_res[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            if (w_ld3) begin
                r_s3_valid <= i_valid;
            end
            if (w_ld4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (w_ld5) begin
                r_s5_valid <= r_s4_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld3 && i_valid) begin
            r_s3 <= i_xact;
        end
        if (w_ld4 && r_s3_valid) begin
            r_s4_phi <= w_phi;
            r_s4_plo <= w_plo;
            r_s4_z   <= r_s3.z;
            r_s4_row <= r_s3.row;
        end
        if (w_ld5 && r_s4_valid) begin
            r_s5 <= n_s5;
        end
    end

    assign o_valid = r_s5_valid;
    assign o_item  = r_s5;

endmodule

`default_nettype wire

FILE: src/csr_spmv_scaled_add_core.sv
// top level of the csr sparse matrix-vector scaled-add core: y = alpha*A*x + z
// depends on csrsp_pkg, csrsp_ram, csrsp_mac, csrsp_scale
//
//   channel  | signals                         | transaction
//   ---------+---------------------------------+-----------------------------------
//   input    | i_in_valid, o_in_stall, i_in_data | load x, nonzero, or close row
//   output   | o_out_valid, i_out_stall, o_out_data | one ranked row per close
//   config   | psel, penable, pwrite, paddr, pwdata | damping factor at address 0
//
// one input transaction per cycle while o_in_stall is low; the row sum accumulator
// adds one term a cycle unless a close waiting on the scale side holds it; a close
// reaches the output via the x ram read, multiply, accumulator, split alpha multiply and saturation
// reset clears stage valids, row sum and row counter and loads the default damping
// factor; x is unset
// output stall holds each stage that cannot drain and backs up to o_in_stall
`default_nettype none

module csr_spmv_scaled_add_core #(
    parameter int NODES = 1024
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire csrsp_pkg::t_in_item   i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output csrsp_pkg::t_out_item       o_out_data,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import csrsp_pkg::*;

    localparam int AW = $clog2(NODES);

    logic [30:0]        r_alpha;
    logic [9:0]         r_row_cnt;
    logic [9:0]         n_row_cnt;

    logic               w_accept;
    logic               w_xok;
    logic               w_wr_en;
    logic               w_rd_en;
    logic               w_mac_valid;
    logic               w_mac_ready;
    t_mac_item          w_mac_item;
    logic [31:0]        w_x;
    logic               w_close_valid;
    logic               w_close_ready;
    t_close_xact        w_close_xact;
    logic [10:0]        w_cnt_inc;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_DAMPING) begin
            r_alpha <= pwdata[30:0];
        end
    end

    assign prdata = (paddr[2] == REG_DAMPING) ? {1'b0, r_alpha} : '0;

    assign o_in_stall = !w_mac_ready;
    assign w_accept   = i_in_valid && w_mac_ready;
    assign w_xok      = 32'(i_in_data.index) < NODES;
    assign w_cnt_inc  = {1'b0, r_row_cnt} + 11'd1;

    always_comb begin
        w_wr_en     = 1'b0;
        w_rd_en     = 1'b0;
        w_mac_valid = 1'b0;
        n_row_cnt   = r_row_cnt;
        unique case (i_in_data.mode)
            MODE_LOAD: begin
                w_wr_en   = w_accept && w_xok;
                n_row_cnt = '0;
            end
            MODE_NONZERO: begin
                w_rd_en     = w_accept;
                w_mac_valid = w_accept;
            end
            MODE_CLOSE: begin
                w_mac_valid = w_accept;
                if (w_cnt_inc[10] || 32'(w_cnt_inc) >= NODES) begin
                    n_row_cnt = '0;
                end else begin
                    n_row_cnt = w_cnt_inc[9:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
        end else if (w_accept) begin
            r_row_cnt <= n_row_cnt;
        end
    end

    assign w_mac_item.close = (i_in_data.mode == MODE_CLOSE);
    assign w_mac_item.xok   = w_xok;
    assign w_mac_item.row   = r_row_cnt;
    assign w_mac_item.value = i_in_data.value;

    csrsp_ram #(
        .WIDTH (32),
        .DEPTH (NODES)
    ) u_xram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (AW'(i_in_data.index)),
        .i_wr_data (i_in_data.value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (AW'(i_in_data.index)),
        .o_rd_data (w_x)
    );

    csrsp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mac_valid),
        .i_item  (w_mac_item),
        .i_x     (w_x),
        .o_ready (w_mac_ready),
        .o_valid (w_close_valid),
        .o_xact  (w_close_xact),
        .i_ready (w_close_ready)
    );

    csrsp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_alpha (r_alpha),
        .i_valid (w_close_valid),
        .i_xact  (w_close_xact),
        .o_ready (w_close_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

FILE: dv/csr_spmv_scaled_add_core_tb.sv
// self-checking testbench for csr_spmv_scaled_add_core: loads x, streams csr rows,
// checks each ranked row against a bit-exact predictor; depends on csrsp_pkg and the core
`timescale 1ns / 1ps

module csr_spmv_scaled_add_core_tb;
    import csrsp_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT  = 5000;
    localparam int         SETTLE      = 12;
    localparam int         HOLD_CYCLES = 300;
    localparam int         LARGE_TERMS = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        o_in_stall;
    t_in_item    in_data;
    logic        o_out_valid;
    logic        out_stall;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    csr_spmv_scaled_add_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic signed [31:0] x_vec [1024];
    bit                 x_loaded [1024];
    int                 loaded_cols [$];
    logic signed [47:0] row_acc;
    logic [9:0]         row_ctr;
    logic [30:0]        alpha;
    t_out_item          expected_ranks [$];

    int  errors;
    int  items_sent;
    int  rows_checked;
    int  sat_rows;
    int  quiet_cycles;
    int  damping_writes;
    bit  gaps_on;
    bit  long_hold_req;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_rank(input t_in_item it);
        logic signed [63:0] xv;
        logic signed [63:0] vv;
        logic signed [63:0] sum64;
        logic signed [95:0] a96;
        logic signed [95:0] s96;
        logic signed [95:0] r96;
        t_out_item          res;
        case (it.mode)
            MODE_LOAD: begin
                x_vec[it.index] = it.value;
                if (!x_loaded[it.index]) begin
                    x_loaded[it.index] = 1'b1;
                    loaded_cols.push_back(int'(it.index));
                end
                row_ctr = '0;
            end
            MODE_NONZERO: begin
                xv    = x_vec[it.index];
                vv    = it.value;
                sum64 = row_acc;
                sum64 = sum64 + ((vv * xv) >>> 30);
                if (sum64 > SUM_MAX) sum64 = SUM_MAX;
                if (sum64 < SUM_MIN) sum64 = SUM_MIN;
                row_acc = sum64[47:0];
            end
            MODE_CLOSE: begin
                a96 = {65'd0, alpha};
                s96 = row_acc;
                r96 = it.value;
                r96 = ((a96 * s96) >>> 30) + r96;
                res.saturated = 1'b0;
                if (r96 > 96'sd2147483647) begin
                    r96 = 96'sd2147483647;
                    res.saturated = 1'b1;
                end else if (r96 < -96'sd2147483648) begin
                    r96 = -96'sd2147483648;
                    res.saturated = 1'b1;
                end
                res.row_index  = row_ctr;
                res.rank_value = r96[31:0];
                expected_ranks.push_back(res);
                row_acc = '0;
                row_ctr = row_ctr + 10'd1;
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [9:0] idx,
                             input logic [31:0] val);
        t_in_item it;
        it.mode  = mode;
        it.index = idx;
        it.value = val;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_rank(it);
        if (mode != MODE_SPARE) items_sent++;
    endtask

    function automatic logic [31:0] rand_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: r = 32'h7FFF_FFFF;
            1: r = 32'h8000_0000;
            2: r = 32'h0000_0000;
            3, 4, 5: r = $signed(r) >>> $urandom_range(2, 16);
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [9:0] pick_col();
        return 10'(loaded_cols[$urandom_range(0, loaded_cols.size() - 1)]);
    endfunction

    task automatic send_row(input int nnz, input logic [31:0] z);
        repeat (nnz) send_item(MODE_NONZERO, pick_col(), rand_value());
        send_item(MODE_CLOSE, 10'($urandom), z);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_ranks.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_damping(input logic [30:0] v);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {2'b00, REG_DAMPING} << 2;
        pwdata  <= {1'b0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        alpha = v;
        damping_writes++;
    endtask

    task automatic test_directed();
        send_item(MODE_LOAD, 10'd0, 32'h7FFF_FFFF);
        send_item(MODE_LOAD, 10'd1023, 32'h8000_0000);
        send_item(MODE_LOAD, 10'd1, 32'h4000_0000);
        send_item(MODE_LOAD, 10'd512, rand_value());
        // empty rows give z unchanged
        send_item(MODE_CLOSE, 10'd0, 32'h8000_0000);
        send_item(MODE_CLOSE, 10'd1023, 32'h7FFF_FFFF);
        // positive then negative clip at close
        send_item(MODE_NONZERO, 10'd0, 32'h7FFF_FFFF);
        send_item(MODE_NONZERO, 10'd1023, 32'h8000_0000);
        send_item(MODE_CLOSE, 10'd0, 32'h7FFF_FFFF);
        send_item(MODE_NONZERO, 10'd1023, 32'h7FFF_FFFF);
        send_item(MODE_CLOSE, 10'd0, 32'h8000_0000);
        // spare mode in the middle of a row changes nothing
        send_item(MODE_NONZERO, 10'd1, 32'h4000_0000);
        send_item(MODE_SPARE, 10'h3FF, 32'hFFFF_FFFF);
        send_item(MODE_CLOSE, 10'd0, 32'h0000_0000);
        // load mid-row resets the row counter and keeps the sum
        send_item(MODE_NONZERO, 10'd512, rand_value());
        send_item(MODE_LOAD, 10'd2, rand_value());
        send_item(MODE_CLOSE, 10'd0, rand_value());
        send_item(MODE_NONZERO, 10'd1, 32'h0000_0000);
        send_item(MODE_CLOSE, 10'h2AA, 32'h0000_0000);
    endtask

    task automatic test_damping_settings();
        logic [30:0] settings [5];
        settings = '{31'd0, 31'h4000_0000, 31'd1, 31'($urandom_range(0, 1 << 30)),
                     ALPHA_RESET};
        foreach (settings[s]) begin
            set_damping(settings[s]);
            for (int r = 0; r < 4; r++) send_row(r, rand_value());
        end
    endtask

    task automatic test_empty_rows();
        send_item(MODE_LOAD, 10'd3, rand_value());
        for (int r = 0; r < 40; r++) begin
            if ($urandom_range(0, 15) == 0) send_row(1, rand_value());
            else send_item(MODE_CLOSE, 10'($urandom), rand_value());
        end
    endtask

    task automatic test_large_sums();
        gaps_on = 1'b0;
        send_item(MODE_LOAD, 10'd7, 32'h8000_0000);
        repeat (LARGE_TERMS) send_item(MODE_NONZERO, 10'd7, 32'h8000_0000);
        send_item(MODE_NONZERO, 10'd7, 32'h7FFF_FFFF);
        send_item(MODE_CLOSE, 10'd0, rand_value());
        repeat (LARGE_TERMS) send_item(MODE_NONZERO, 10'd7, 32'h7FFF_FFFF);
        send_item(MODE_NONZERO, 10'd7, 32'h8000_0000);
        send_item(MODE_CLOSE, 10'd0, rand_value());
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        long_hold_req = 1'b1;
        for (int r = 0; r < 20; r++) send_row($urandom_range(0, 3), rand_value());
        // hold the sender until the output side has caught up
        drain_results();
    endtask

    task automatic test_random_traffic(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) begin
            case ($urandom_range(0, 19))
                0: repeat ($urandom_range(1, 4))
                       send_item(MODE_LOAD, 10'($urandom), rand_value());
                1: send_item(MODE_SPARE, 10'($urandom), $urandom);
                2: send_item(MODE_CLOSE, 10'($urandom), rand_value());
                default: send_row($urandom_range(0, 6), rand_value());
            endcase
        end
    endtask

    initial begin
        errors         = 0;
        items_sent     = 0;
        rows_checked   = 0;
        sat_rows       = 0;
        damping_writes = 0;
        gaps_on        = 1'b1;
        long_hold_req  = 1'b0;
        row_acc        = '0;
        row_ctr        = '0;
        alpha          = ALPHA_RESET;
        i_rst_n  <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_damping_settings();
        test_empty_rows();
        test_large_sums();
        test_backpressure();
        for (int p = 0; p < 3; p++) begin
            test_random_traffic(150);
            set_damping(31'($urandom_range(0, 1 << 30)));
        end
        gaps_on = 1'b0;
        test_random_traffic(120);
        drain_results();

        $display("covered %0d transactions, %0d rows checked, %0d clipped rows",
                 items_sent, rows_checked, sat_rows);
        $display("damping writes: %0d, including zero and full scale", damping_writes);
        if (errors == 0 && expected_ranks.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // output stall: random bursts, plus one long hold on request
    initial begin
        out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                out_stall <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 6) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : rank_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_ranks.size() == 0) begin
                $error("unexpected result: row_index %0d rank_value %0d",
                       o_out_data.row_index, o_out_data.rank_value);
                errors++;
            end else begin
                want = expected_ranks.pop_front();
                rows_checked++;
                if (o_out_data.saturated) sat_rows++;
                if (o_out_data.row_index !== want.row_index) begin
                    $error("row_index: expected %0d actual %0d",
                           want.row_index, o_out_data.row_index);
                    errors++;
                end
                if (o_out_data.rank_value !== want.rank_value) begin
                    $error("rank_value: expected %0d actual %0d",
                           want.rank_value, o_out_data.rank_value);
                    errors++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $error("saturated: expected %0b actual %0b",
                           want.saturated, o_out_data.saturated);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d rows outstanding", expected_ranks.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial quiet_cycles = 0;

endmodule

FILE: filelist.f
src/csrsp_pkg.sv
src/csrsp_ram.sv
src/csrsp_mac.sv
src/csrsp_scale.sv
src/csr_spmv_scaled_add_core.sv
dv/csr_spmv_scaled_add_core_tb.sv
